/* rtl/core/gbn_pkg.sv */
// ---------------------------------------------------------------------------
// gbn_pkg
// shared constants, codes and default sizes of the go-back-n sender window
// ---------------------------------------------------------------------------
package gbn_pkg;

    // default sizes, overridable on the top level
    localparam int WINDOW_DEF       = 8;
    localparam int SEQ_BITS_DEF     = 16;
    localparam int PAYLOAD_BITS_DEF = 32;

    // timer duration field and register
    localparam int TICK_W = 16;
    localparam logic [TICK_W-1:0] TIMEOUT_TICKS_RST = 16'd20;

    // apb port geometry
    localparam int APB_DW = 32;
    localparam int ADDR_W = 3;
    localparam int REG_IDX_W = ADDR_W - 2;

    // register map, index = byte address / 4
    localparam logic [REG_IDX_W-1:0] REG_TIMEOUT_TICKS = '0;

    // request opcodes; the fourth code is unused and ignored
    localparam logic [1:0] OP_SEND    = 2'd0;
    localparam logic [1:0] OP_ACK     = 2'd1;
    localparam logic [1:0] OP_TIMEOUT = 2'd2;

    // timer commands
    typedef enum logic [1:0] {
        TMR_NONE    = 2'd0,
        TMR_START   = 2'd1,
        TMR_RESTART = 2'd2,
        TMR_STOP    = 2'd3
    } tmr_cmd_t;

endpackage

/* rtl/core/gbn_req_if.sv */
// ---------------------------------------------------------------------------
// gbn_req_if
// request channel: send, acknowledgement or timer expiry, valid/ready
// ---------------------------------------------------------------------------
interface gbn_req_if #(
    parameter int SEQ_BITS     = gbn_pkg::SEQ_BITS_DEF,
    parameter int PAYLOAD_BITS = gbn_pkg::PAYLOAD_BITS_DEF
);
    logic                    valid;
    logic                    ready;
    logic [1:0]              op;
    logic [PAYLOAD_BITS-1:0] payload;
    logic [SEQ_BITS-1:0]     ack_num;
    logic                    ack_checksum_ok;

    modport source (
        output valid, op, payload, ack_num, ack_checksum_ok,
        input  ready
    );

    modport sink (
        input  valid, op, payload, ack_num, ack_checksum_ok,
        output ready
    );
endinterface

/* rtl/core/gbn_rsp_if.sv */
// ---------------------------------------------------------------------------
// gbn_rsp_if
// result channel: packet to transmit plus timer command, valid/ready
// ---------------------------------------------------------------------------
interface gbn_rsp_if #(
    parameter int SEQ_BITS     = gbn_pkg::SEQ_BITS_DEF,
    parameter int PAYLOAD_BITS = gbn_pkg::PAYLOAD_BITS_DEF
);
    logic                      valid;
    logic                      ready;
    logic                      accepted;
    logic                      pkt_valid;
    logic [SEQ_BITS-1:0]       pkt_seq;
    logic [PAYLOAD_BITS-1:0]   pkt_payload;
    logic [1:0]                timer_cmd;
    logic [SEQ_BITS-1:0]       timer_seq;
    logic [gbn_pkg::TICK_W-1:0] timer_ticks;
    logic                      window_full;
    logic                      last;

    modport source (
        output valid, accepted, pkt_valid, pkt_seq, pkt_payload, timer_cmd,
               timer_seq, timer_ticks, window_full, last,
        input  ready
    );

    modport sink (
        input  valid, accepted, pkt_valid, pkt_seq, pkt_payload, timer_cmd,
               timer_seq, timer_ticks, window_full, last,
        output ready
    );
endinterface

/* rtl/core/gbn_ram.sv */
// ---------------------------------------------------------------------------
// gbn_ram
// generic simple dual-port ram, one write and one registered read port
// ---------------------------------------------------------------------------
module gbn_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 8
) (
    input  logic                                    clk,
    input  logic                                    we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                        wdata,
    input  logic                                    re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                        rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read, holds while re is low
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;
endmodule

/* rtl/core/gbn_ctrl.sv */
// ---------------------------------------------------------------------------
// gbn_ctrl
// window control: sequence state, payload store, replay walker, result stage
// ---------------------------------------------------------------------------
module gbn_ctrl #(
    parameter int WINDOW       = gbn_pkg::WINDOW_DEF,
    parameter int SEQ_BITS     = gbn_pkg::SEQ_BITS_DEF,
    parameter int PAYLOAD_BITS = gbn_pkg::PAYLOAD_BITS_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    gbn_req_if.sink                    req,
    gbn_rsp_if.source                  rsp,
    input  logic [gbn_pkg::TICK_W-1:0] timeout_ticks
);
    import gbn_pkg::*;

    localparam int SLOT_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int SW1    = SLOT_W + 1;
    localparam int CNT_W  = $clog2(WINDOW + 1);
    localparam longint unsigned SEQ_SPACE = (64'd1 << SEQ_BITS) - 64'd1;
    localparam int EFF_WIN = (longint'(WINDOW) < SEQ_SPACE) ? WINDOW : int'(SEQ_SPACE);

    typedef enum logic {
        ST_IDLE,
        ST_REPLAY
    } state_t;

    typedef struct packed {
        logic                    accepted;
        logic                    pkt_valid;
        logic [SEQ_BITS-1:0]     pkt_seq;
        logic [PAYLOAD_BITS-1:0] pkt_payload;
        tmr_cmd_t                timer_cmd;
        logic [SEQ_BITS-1:0]     timer_seq;
        logic [TICK_W-1:0]       timer_ticks;
        logic                    window_full;
        logic                    last;
    } rsp_t;

    // ring slot advance, wraps at the window size
    function automatic logic [SLOT_W-1:0] slot_add(input logic [SLOT_W-1:0] slot,
                                                   input logic [CNT_W-1:0] cnt);
        logic [SW1-1:0] sum;
        sum = {1'b0, slot} + SW1'(cnt);
        if (sum >= SW1'(WINDOW))
        begin
            sum = sum - SW1'(WINDOW);
        end
        return sum[SLOT_W-1:0];
    endfunction

    state_t              state_reg;
    logic [SEQ_BITS-1:0] base_reg, base_next;
    logic [SEQ_BITS-1:0] next_seq_reg, next_seq_next;
    logic [CNT_W-1:0]    outstanding_reg, outstanding_next;
    logic [SLOT_W-1:0]   head_reg, head_next;

    logic [CNT_W-1:0]    rp_left_reg;
    logic                rp_first_reg;
    logic [SEQ_BITS-1:0] rp_seq_reg;
    logic [SLOT_W-1:0]   rp_slot_reg;

    logic out_valid_reg, skid_valid_reg;
    rsp_t out_data_reg, skid_data_reg;

    logic                    space, acc, push, start_rp, wr_ok, rp_push;
    logic [SEQ_BITS-1:0]     ack_ofs;
    logic [CNT_W-1:0]        ack_cnt, ack_left;
    rsp_t                    res_idle, res_rp, res;
    logic                    ram_we, ram_re;
    logic [SLOT_W-1:0]       ram_waddr, ram_raddr;
    logic [PAYLOAD_BITS-1:0] ram_rdata;

    // handshake
    assign space   = !skid_valid_reg;
    assign req.ready = (state_reg == ST_IDLE) && space;
    assign acc     = req.valid && req.ready;
    assign rp_push = (state_reg == ST_REPLAY) && space;
    assign push    = (acc && !start_rp) || rp_push;

    // single-word items: send, ack, empty timeout, unused opcode
    always_comb
    begin
        base_next        = base_reg;
        next_seq_next    = next_seq_reg;
        outstanding_next = outstanding_reg;
        head_next        = head_reg;
        start_rp         = 1'b0;
        wr_ok            = 1'b0;
        ram_waddr        = slot_add(head_reg, outstanding_reg);
        ack_ofs          = req.ack_num - base_reg;
        ack_cnt          = CNT_W'(ack_ofs) + CNT_W'(1);
        ack_left         = outstanding_reg - ack_cnt;
        res_idle         = '0;
        res_idle.timer_cmd = TMR_NONE;
        res_idle.last    = 1'b1;
        case (req.op)
            OP_SEND:
            begin
                if (outstanding_reg < CNT_W'(EFF_WIN))
                begin
                    wr_ok                = 1'b1;
                    outstanding_next     = outstanding_reg + CNT_W'(1);
                    next_seq_next        = next_seq_reg + SEQ_BITS'(1);
                    res_idle.accepted    = 1'b1;
                    res_idle.pkt_valid   = 1'b1;
                    res_idle.pkt_seq     = next_seq_reg;
                    res_idle.pkt_payload = req.payload;
                    if (outstanding_reg == '0)
                    begin
                        res_idle.timer_cmd   = TMR_START;
                        res_idle.timer_seq   = next_seq_reg;
                        res_idle.timer_ticks = timeout_ticks;
                    end
                end
            end
            OP_ACK:
            begin
                if (req.ack_checksum_ok && (outstanding_reg != '0) &&
                    (ack_ofs < SEQ_BITS'(outstanding_reg)))
                begin
                    base_next        = req.ack_num + SEQ_BITS'(1);
                    head_next        = slot_add(head_reg, ack_cnt);
                    outstanding_next = ack_left;
                    if (ack_left != '0)
                    begin
                        res_idle.timer_cmd   = TMR_RESTART;
                        res_idle.timer_seq   = base_next;
                        res_idle.timer_ticks = timeout_ticks;
                    end
                    else
                    begin
                        res_idle.timer_cmd = TMR_STOP;
                        res_idle.timer_seq = base_reg;
                    end
                end
            end
            OP_TIMEOUT:
            begin
                start_rp = (outstanding_reg != '0);
            end
            default:
            begin
                start_rp = 1'b0;
            end
        endcase
        res_idle.window_full = (outstanding_next >= CNT_W'(EFF_WIN));
    end

    // replayed packet, payload comes from the ram read register
    always_comb
    begin
        res_rp             = '0;
        res_rp.pkt_valid   = 1'b1;
        res_rp.pkt_seq     = rp_seq_reg;
        res_rp.pkt_payload = ram_rdata;
        res_rp.timer_cmd   = rp_first_reg ? TMR_RESTART : TMR_NONE;
        res_rp.timer_seq   = rp_first_reg ? rp_seq_reg : '0;
        res_rp.timer_ticks = rp_first_reg ? timeout_ticks : '0;
        res_rp.window_full = (outstanding_reg >= CNT_W'(EFF_WIN));
        res_rp.last        = (rp_left_reg == CNT_W'(1));
    end

    assign res = (state_reg == ST_REPLAY) ? res_rp : res_idle;

    // payload store; writes happen only in idle, reads on acceptance of a timeout and while replaying
    assign ram_we    = acc && wr_ok;
    assign ram_re    = (acc && start_rp) || (rp_push && (rp_left_reg != CNT_W'(1)));
    assign ram_raddr = (state_reg == ST_REPLAY) ? slot_add(rp_slot_reg, CNT_W'(1)) : head_reg;

    gbn_ram #(
        .WIDTH (PAYLOAD_BITS),
        .DEPTH (WINDOW)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (req.payload),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // window state, replay sequencer and result valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            base_reg        <= SEQ_BITS'(1);
            next_seq_reg    <= SEQ_BITS'(1);
            outstanding_reg <= '0;
            head_reg        <= '0;
            rp_left_reg     <= '0;
            rp_first_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
            skid_valid_reg  <= 1'b0;
        end
        else
        begin
            if (acc)
            begin
                base_reg        <= base_next;
                next_seq_reg    <= next_seq_next;
                outstanding_reg <= outstanding_next;
                head_reg        <= head_next;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (acc && start_rp)
                    begin
                        state_reg    <= ST_REPLAY;
                        rp_left_reg  <= outstanding_reg;
                        rp_first_reg <= 1'b1;
                    end
                end
                ST_REPLAY:
                begin
                    if (rp_push)
                    begin
                        rp_first_reg <= 1'b0;
                        rp_left_reg  <= rp_left_reg - CNT_W'(1);
                        if (rp_left_reg == CNT_W'(1))
                        begin
                            state_reg <= ST_IDLE;
                        end
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
            if (!out_valid_reg || rsp.ready)
            begin
                if (skid_valid_reg)
                begin
                    skid_valid_reg <= 1'b0;
                end
                else
                begin
                    out_valid_reg <= push;
                end
            end
            else if (push)
            begin
                skid_valid_reg <= 1'b1;
            end
        end
    end

    // result words and replay pointers
    always_ff @(posedge clk)
    begin
        if (acc && start_rp)
        begin
            rp_seq_reg  <= base_reg;
            rp_slot_reg <= head_reg;
        end
        else if (rp_push)
        begin
            rp_seq_reg  <= rp_seq_reg + SEQ_BITS'(1);
            rp_slot_reg <= slot_add(rp_slot_reg, CNT_W'(1));
        end
        if (!out_valid_reg || rsp.ready)
        begin
            out_data_reg <= skid_valid_reg ? skid_data_reg : res;
        end
        else if (push)
        begin
            skid_data_reg <= res;
        end
    end

    // result channel
    assign rsp.valid       = out_valid_reg;
    assign rsp.accepted    = out_data_reg.accepted;
    assign rsp.pkt_valid   = out_data_reg.pkt_valid;
    assign rsp.pkt_seq     = out_data_reg.pkt_seq;
    assign rsp.pkt_payload = out_data_reg.pkt_payload;
    assign rsp.timer_cmd   = out_data_reg.timer_cmd;
    assign rsp.timer_seq   = out_data_reg.timer_seq;
    assign rsp.timer_ticks = out_data_reg.timer_ticks;
    assign rsp.window_full = out_data_reg.window_full;
    assign rsp.last        = out_data_reg.last;
endmodule

/* rtl/core/go_back_n_sender_window_top.sv */
// ---------------------------------------------------------------------------
// go_back_n_sender_window_top
// go-back-n arq sender: window state, payload store and timer commands
// ---------------------------------------------------------------------------
// usage
//   req carries one word per item: send a payload, a cumulative ack, or a
//   retransmission timer expiry. rsp returns result words, each with the
//   packet to transmit (if any), a timer command and the window-full flag;
//   last marks the final word of an item.
//   sends, acks and empty timeouts give one registered word each, and are
//   taken at one per cycle while rsp drains.
//   a timeout with k packets outstanding replays them from the payload ram:
//   the first word passes the ram read register and then the output register,
//   then one per cycle while rsp drains; req is held off until all k are sent.
//   an output register plus a one-word skid buffer part the two sides, so a
//   stalled rsp holds its word and req stays ready until the skid word fills.
//   reset sets base and next sequence numbers to 1, empties the window and
//   loads timeout_ticks with 20; the payload ram is not cleared, since only
//   slots of outstanding packets are ever read.
//   timeout_ticks sits on the apb port at byte address 0.
// ---------------------------------------------------------------------------
module go_back_n_sender_window_top #(
    parameter int WINDOW       = gbn_pkg::WINDOW_DEF,
    parameter int SEQ_BITS     = gbn_pkg::SEQ_BITS_DEF,
    parameter int PAYLOAD_BITS = gbn_pkg::PAYLOAD_BITS_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    gbn_req_if.sink                    req,
    gbn_rsp_if.source                  rsp,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [gbn_pkg::ADDR_W-1:0] paddr,
    input  logic [gbn_pkg::APB_DW-1:0] pwdata,
    output logic [gbn_pkg::APB_DW-1:0] prdata,
    output logic                       pready
);
    import gbn_pkg::*;

    logic [TICK_W-1:0]    timeout_ticks_reg, timeout_ticks_next;
    logic [REG_IDX_W-1:0] reg_idx;
    logic                 apb_wr;

    // apb register decode
    assign pready  = 1'b1;
    assign reg_idx = paddr[ADDR_W-1:2];
    assign apb_wr  = psel && penable && pwrite && pready;

    always_comb
    begin
        timeout_ticks_next = timeout_ticks_reg;
        prdata             = '0;
        unique case (reg_idx)
            REG_TIMEOUT_TICKS:
            begin
                prdata = APB_DW'(timeout_ticks_reg);
                if (apb_wr)
                begin
                    timeout_ticks_next = pwdata[TICK_W-1:0];
                end
            end
            default:
            begin
                prdata = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_ticks_reg <= TIMEOUT_TICKS_RST;
        end
        else
        begin
            timeout_ticks_reg <= timeout_ticks_next;
        end
    end

    // window control
    gbn_ctrl #(
        .WINDOW       (WINDOW),
        .SEQ_BITS     (SEQ_BITS),
        .PAYLOAD_BITS (PAYLOAD_BITS)
    ) u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .req           (req),
        .rsp           (rsp),
        .timeout_ticks (timeout_ticks_reg)
    );

`ifndef NO_ASSERTIONS
    // a register write lands in timeout_ticks
    a_cfg_write: assert property (@(posedge clk) disable iff (!rst_n)
        (apb_wr && (reg_idx == REG_TIMEOUT_TICKS))
            |=> (timeout_ticks_reg == $past(pwdata[TICK_W-1:0])))
        else $error("timeout_ticks write lost");

    // an accepted send is a single word carrying its packet
    a_send_word: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.accepted) |-> (rsp.pkt_valid && rsp.last))
        else $error("accepted send without packet or last");

    // only replays give several words, and each carries a packet
    a_multi_word: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && !rsp.last) |-> (rsp.pkt_valid && !rsp.accepted))
        else $error("non-final word is not a replayed packet");

    // durations go out only with start and restart commands
    a_ticks_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && (rsp.timer_cmd == TMR_NONE || rsp.timer_cmd == TMR_STOP))
            |-> (rsp.timer_ticks == '0))
        else $error("timer ticks without a start command");
`endif
endmodule
